// ----- hw/rtl/fts_pkg.sv -----
// Shared types, constants and controller/datapath interface structs for the frame time monitor.
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

    localparam int unsigned FTS_RING_SECONDS = 2048;
    localparam int unsigned FTS_CFG_IDX_W    = 8;
    localparam logic [31:0] FTS_SECOND_LEN_RESET = 32'd1000000;

    localparam logic [1:0] MODE_ACCOUNT = 2'd0;
    localparam logic [1:0] MODE_BEGIN   = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;
    localparam logic [1:0] MODE_READ    = 2'd3;

    localparam logic [1:0] BUCKET_SUBMIT = 2'd0;
    localparam logic [1:0] BUCKET_GPWAIT = 2'd1;
    localparam logic [1:0] BUCKET_VSYNC  = 2'd2;
    localparam logic [1:0] BUCKET_NONE   = 2'd3;

    localparam logic [FTS_CFG_IDX_W-1:0] CFG_ENABLE     = 8'd0;
    localparam logic [FTS_CFG_IDX_W-1:0] CFG_SECOND_LEN = 8'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  bucket;
        logic [31:0] start_us;
        logic [31:0] now_us;
        logic [31:0] read_second;
    } t_in_item;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] frame_count;
        logic [31:0] frame_avg_us;
        logic [31:0] frame_max_us;
        logic [31:0] cpu_avg_us;
        logic [31:0] submit_avg_us;
        logic [31:0] submit_max_us;
        logic [31:0] gpwait_avg_us;
        logic [31:0] gpwait_max_us;
        logic [31:0] vsync_avg_us;
        logic [31:0] vsync_max_us;
        logic [31:0] seconds_recorded;
    } t_out_item;

    // One second of the ring.
    typedef struct packed {
        logic [31:0] frames;
        logic [31:0] fsum;
        logic [31:0] fmax;
        logic [31:0] bsum0;
        logic [31:0] bsum1;
        logic [31:0] bsum2;
        logic [31:0] bmax0;
        logic [31:0] bmax1;
        logic [31:0] bmax2;
    } t_entry;

    typedef struct packed {
        logic       clr;
        logic       take;
        logic       account;
        logic       frame_begin;
        logic       fe_rd;
        logic       fe_wr;
        logic       roll_wr;
        logic       rd_prep;
        logic       rd_rd;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       load_out;
        logic       out_ok;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] mode;
        logic       enable;
        logic       roll;
        logic       rd_ok;
        logic       frames_zero;
        logic       div_done;
        logic       out_full;
    } t_status;

endpackage
`default_nettype wire

// ----- hw/rtl/fts_div.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fts_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[31]};
    assign ge     = rem_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, i_divisor}) : rem_sh[31:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- hw/rtl/fts_dp.sv -----
// Datapath: registers, second ring memory, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module fts_dp #(
    parameter int unsigned RING_SECONDS = fts_pkg::FTS_RING_SECONDS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fts_pkg::t_in_item                   i_in_data,
    input  wire logic                                i_cfg_valid,
    input  wire logic [fts_pkg::FTS_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                         i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output fts_pkg::t_out_item                       o_out_data,
    input  wire fts_pkg::t_cmd                       i_cmd,
    output fts_pkg::t_status                         o_st
);
    import fts_pkg::*;

    localparam int unsigned SW = $clog2(RING_SECONDS);

    t_entry      mem [RING_SECONDS];
    t_entry      r_rdata;
    t_in_item    r_item;
    logic        r_enable;
    logic [31:0] r_sec_len;
    logic [31:0] r_index;
    logic [31:0] r_sec_start;
    logic [31:0] r_frame_start;
    logic [31:0] r_bucket [3];
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_clr_addr;
    logic [SW-1:0] r_rd_slot;
    logic        r_rd_ok;
    logic [31:0] r_q [4];
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] ft;
    logic [31:0] since_sec;
    logic        roll;
    logic [31:0] rd_dist;
    logic [SW-1:0] dist_n;
    logic [SW:0] rd_slot_c;
    logic        rd_ok_c;
    logic [SW-1:0] slot_next;
    t_entry      upd;
    logic        we;
    logic [SW-1:0] waddr;
    t_entry      wdata;
    logic [SW-1:0] raddr;
    logic [31:0] dividend;
    logic        div_done;
    logic [31:0] quotient;
    logic [33:0] waits;
    logic [33:0] favg_x;
    t_out_item   res;

    // Frame end update of the current entry.
    assign ft        = r_item.now_us - r_frame_start;
    assign since_sec = r_item.now_us - r_sec_start;
    assign roll      = since_sec >= r_sec_len;

    always_comb begin
        upd       = r_rdata;
        upd.frames = r_rdata.frames + 32'd1;
        upd.fsum  = r_rdata.fsum + ft;
        upd.fmax  = (ft > r_rdata.fmax) ? ft : r_rdata.fmax;
        upd.bsum0 = r_rdata.bsum0 + r_bucket[0];
        upd.bsum1 = r_rdata.bsum1 + r_bucket[1];
        upd.bsum2 = r_rdata.bsum2 + r_bucket[2];
        upd.bmax0 = (r_bucket[0] > r_rdata.bmax0) ? r_bucket[0] : r_rdata.bmax0;
        upd.bmax1 = (r_bucket[1] > r_rdata.bmax1) ? r_bucket[1] : r_rdata.bmax1;
        upd.bmax2 = (r_bucket[2] > r_rdata.bmax2) ? r_bucket[2] : r_rdata.bmax2;
    end

    // The ring slot follows the second index; the index wrapping to zero lands on slot zero.
    assign slot_next = ((r_index == '1) || (r_slot == SW'(RING_SECONDS - 1))) ? '0
                       : SW'(r_slot + 1'b1);

    // Read window: the asked second is at most RING_SECONDS - 1 behind the current one.
    assign rd_dist   = r_index - r_item.read_second;
    assign dist_n    = rd_dist[SW-1:0];
    assign rd_ok_c   = r_enable && (r_item.read_second <= r_index)
                       && (rd_dist < 32'(RING_SECONDS));
    assign rd_slot_c = (r_slot >= dist_n) ? {1'b0, r_slot} - {1'b0, dist_n}
                       : {1'b0, r_slot} + (SW+1)'(RING_SECONDS) - {1'b0, dist_n};

    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = '0;
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
        end else if (i_cmd.fe_wr) begin
            we    = 1'b1;
            wdata = upd;
        end else if (i_cmd.roll_wr) begin
            we    = 1'b1;
        end
        raddr = i_cmd.rd_rd ? r_rd_slot : r_slot;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.fe_rd || i_cmd.rd_rd) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_sec_len     <= FTS_SECOND_LEN_RESET;
            r_index       <= 32'd0;
            r_sec_start   <= 32'd0;
            r_frame_start <= 32'd0;
            r_bucket[0]   <= 32'd0;
            r_bucket[1]   <= 32'd0;
            r_bucket[2]   <= 32'd0;
            r_slot        <= '0;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_SECOND_LEN) begin
                    r_sec_len <= i_cfg_data;
                end
            end
            if (i_cmd.clr) begin
                r_clr_addr <= SW'(r_clr_addr + 1'b1);
            end
            if (i_cmd.account && (r_item.bucket != BUCKET_NONE)) begin
                r_bucket[r_item.bucket] <= r_bucket[r_item.bucket]
                                           + (r_item.now_us - r_item.start_us);
            end
            if (i_cmd.frame_begin) begin
                r_frame_start <= r_item.now_us;
                r_bucket[0]   <= 32'd0;
                r_bucket[1]   <= 32'd0;
                r_bucket[2]   <= 32'd0;
            end
            if (i_cmd.fe_wr && roll) begin
                r_sec_start <= r_item.now_us;
                r_index     <= r_index + 32'd1;
                r_slot      <= slot_next;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in_data;
        end
        if (i_cmd.rd_prep) begin
            r_rd_slot <= rd_slot_c[SW-1:0];
            r_rd_ok   <= rd_ok_c;
        end
        if (i_cmd.div_store) begin
            r_q[i_cmd.div_sel] <= quotient;
        end
        if (i_cmd.load_out) begin
            r_out <= res;
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            2'd0:    dividend = r_rdata.fsum;
            2'd1:    dividend = r_rdata.bsum0;
            2'd2:    dividend = r_rdata.bsum1;
            default: dividend = r_rdata.bsum2;
        endcase
    end

    fts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_rdata.frames),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Quotients: 0 frame, 1 submit, 2 gp wait, 3 vsync.
    assign waits  = {2'b00, r_q[2]} + {2'b00, r_q[3]};
    assign favg_x = {2'b00, r_q[0]};

    always_comb begin
        res                  = '0;
        res.seconds_recorded = r_index;
        if (i_cmd.out_ok) begin
            res.valid_res     = 1'b1;
            res.frame_count   = r_rdata.frames;
            res.frame_avg_us  = r_q[0];
            res.frame_max_us  = r_rdata.fmax;
            res.cpu_avg_us    = (favg_x > waits) ? 32'(favg_x - waits) : 32'd0;
            res.submit_avg_us = r_q[1];
            res.submit_max_us = r_rdata.bmax0;
            res.gpwait_avg_us = r_q[2];
            res.gpwait_max_us = r_rdata.bmax1;
            res.vsync_avg_us  = r_q[3];
            res.vsync_max_us  = r_rdata.bmax2;
        end
    end

    assign o_st.clr_last    = (r_clr_addr == SW'(RING_SECONDS - 1));
    assign o_st.mode        = r_item.mode;
    assign o_st.enable      = r_enable;
    assign o_st.roll        = roll;
    assign o_st.rd_ok       = r_rd_ok;
    assign o_st.frames_zero = (r_rdata.frames == 32'd0);
    assign o_st.div_done    = div_done;
    assign o_st.out_full    = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- hw/rtl/fts_ctrl.sv -----
// Controller state machine that sequences the datapath for each event.
`timescale 1ns / 1ps
`default_nettype none
module fts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire fts_pkg::t_status i_st,
    output fts_pkg::t_cmd         o_cmd
);
    import fts_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_FE_WR, S_FE_ROLL, S_RD_ISSUE,
        S_RD_CHK, S_DIV_GO, S_DIV_RUN, S_RESULT
    } t_state;

    t_state     r_state;
    logic [1:0] r_k;
    logic       r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= 2'd0;
            r_ok    <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_st.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    if (i_st.mode == MODE_READ) begin
                        r_state <= S_RD_ISSUE;
                    end else if (i_st.enable && (i_st.mode == MODE_END)) begin
                        r_state <= S_FE_WR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FE_WR: begin
                    r_state <= i_st.roll ? S_FE_ROLL : S_IDLE;
                end
                S_FE_ROLL: begin
                    r_state <= S_IDLE;
                end
                S_RD_ISSUE: begin
                    r_k <= 2'd0;
                    if (i_st.rd_ok) begin
                        r_state <= S_RD_CHK;
                    end else begin
                        r_ok    <= 1'b0;
                        r_state <= S_RESULT;
                    end
                end
                S_RD_CHK: begin
                    if (i_st.frames_zero) begin
                        r_ok    <= 1'b0;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    if (i_st.div_done) begin
                        if (r_k == 2'd3) begin
                            r_ok    <= 1'b1;
                            r_state <= S_RESULT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_RESULT: begin
                    if (!i_st.out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd             = '0;
        o_cmd.div_sel     = r_k;
        o_cmd.out_ok      = r_ok;
        o_cmd.clr         = (r_state == S_CLEAR);
        o_cmd.take        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.account     = (r_state == S_DISPATCH) && i_st.enable
                            && (i_st.mode == MODE_ACCOUNT);
        o_cmd.frame_begin = (r_state == S_DISPATCH) && i_st.enable
                            && (i_st.mode == MODE_BEGIN);
        o_cmd.fe_rd       = (r_state == S_DISPATCH) && i_st.enable
                            && (i_st.mode == MODE_END);
        o_cmd.rd_prep     = (r_state == S_DISPATCH);
        o_cmd.fe_wr       = (r_state == S_FE_WR);
        o_cmd.roll_wr     = (r_state == S_FE_ROLL);
        o_cmd.rd_rd       = (r_state == S_RD_ISSUE) && i_st.rd_ok;
        o_cmd.div_start   = (r_state == S_DIV_GO);
        o_cmd.div_store   = (r_state == S_DIV_RUN) && i_st.div_done;
        o_cmd.load_out    = (r_state == S_RESULT) && !i_st.out_full;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/per_second_frame_time_stats_top.sv -----
// Top level of the per-second frame time monitor.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An account or frame begin event is taken and then applied; a frame end does a
// read-modify-write of the ring entry through the memory's read and write ports, plus
// one write to clear the next entry on a rollover. A read of a stored second with
// frames runs four divisions by the frame count, one after another, on one shared
// divider at one quotient bit per cycle. After reset the block sweeps the ring clear
// before it accepts its first input transfer; configuration transfers are taken at any time.
// The result sits in an output register, so a stalled output holds only a read that
// finishes while the previous result has not been taken yet.
`timescale 1ns / 1ps
`default_nettype none
module per_second_frame_time_stats_top #(
    parameter int unsigned RING_SECONDS = fts_pkg::FTS_RING_SECONDS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire fts_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output fts_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fts_pkg::FTS_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data
);
    import fts_pkg::*;

    t_cmd    cmd;
    t_status st;

    // Configuration writes land directly in the datapath registers.
    assign o_cfg_ready = 1'b1;

    fts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    fts_dp #(
        .RING_SECONDS (RING_SECONDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_st        (st)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/fts_chk.sv -----
// Port-level checker for the frame time monitor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fts_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire fts_pkg::t_out_item o_out_data
);
    import fts_pkg::*;

    // The ring is being cleared right after reset.
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.valid_res |->
            o_out_data.frame_count == 32'd0 && o_out_data.frame_avg_us == 32'd0 &&
            o_out_data.cpu_avg_us == 32'd0 && o_out_data.vsync_max_us == 32'd0)
        else $error("invalid result carries data");

    a_valid_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.valid_res |->
            o_out_data.frame_count != 32'd0 &&
            o_out_data.cpu_avg_us <= o_out_data.frame_avg_us)
        else $error("valid result with no frames or cpu above frame average");
endmodule

bind per_second_frame_time_stats_top fts_chk u_fts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the per-second frame time monitor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import fts_pkg::*;

    localparam int unsigned RING = FTS_RING_SECONDS;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in_item i_in_data = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [FTS_CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_in_ready, o_out_valid, o_cfg_ready;
    t_out_item o_out_data;

    per_second_frame_time_stats_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the monitor state, updated as each transfer is accepted.
    logic        mon_enable;
    logic [31:0] mon_sec_len;
    logic [31:0] mon_sec_idx;
    logic [31:0] mon_sec_start;
    logic [31:0] mon_frame_start;
    logic [31:0] mon_bucket [3];
    t_entry      mon_ring [RING];

    t_out_item   pending_reads [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          sink_hold = 1'b0;
    bit          sink_calm = 1'b0;
    bit          src_calm = 1'b0;

    function automatic t_out_item read_second_stats(logic [31:0] sec);
        t_out_item r;
        t_entry e;
        logic [31:0] n, favg, gavg, vavg;
        logic [32:0] waits;
        r = '0;
        r.seconds_recorded = mon_sec_idx;
        if (!mon_enable || sec > mon_sec_idx || (mon_sec_idx - sec) >= RING)
            return r;
        e = mon_ring[sec % RING];
        n = e.frames;
        if (n == 0)
            return r;
        favg = e.fsum / n;
        gavg = e.bsum1 / n;
        vavg = e.bsum2 / n;
        waits = {1'b0, gavg} + {1'b0, vavg};
        r.valid_res = 1'b1;
        r.frame_count = n;
        r.frame_avg_us = favg;
        r.frame_max_us = e.fmax;
        r.cpu_avg_us = ({1'b0, favg} > waits) ? 32'({1'b0, favg} - waits) : 32'd0;
        r.submit_avg_us = e.bsum0 / n;
        r.submit_max_us = e.bmax0;
        r.gpwait_avg_us = gavg;
        r.gpwait_max_us = e.bmax1;
        r.vsync_avg_us = vavg;
        r.vsync_max_us = e.bmax2;
        return r;
    endfunction

    // Frame end: fold the frame into the current second, then maybe roll over.
    task automatic fold_frame(logic [31:0] now);
        logic [31:0] ft;
        int slot;
        ft = now - mon_frame_start;
        slot = mon_sec_idx % RING;
        mon_ring[slot].frames += 1;
        mon_ring[slot].fsum += ft;
        if (ft > mon_ring[slot].fmax) mon_ring[slot].fmax = ft;
        mon_ring[slot].bsum0 += mon_bucket[0];
        mon_ring[slot].bsum1 += mon_bucket[1];
        mon_ring[slot].bsum2 += mon_bucket[2];
        if (mon_bucket[0] > mon_ring[slot].bmax0) mon_ring[slot].bmax0 = mon_bucket[0];
        if (mon_bucket[1] > mon_ring[slot].bmax1) mon_ring[slot].bmax1 = mon_bucket[1];
        if (mon_bucket[2] > mon_ring[slot].bmax2) mon_ring[slot].bmax2 = mon_bucket[2];
        if ((now - mon_sec_start) >= mon_sec_len) begin
            mon_sec_start = now;
            mon_sec_idx += 1;
            mon_ring[mon_sec_idx % RING] = '0;
        end
    endtask

    task automatic apply_event(t_in_item it);
        if (it.mode == MODE_READ) begin
            pending_reads.push_back(read_second_stats(it.read_second));
            return;
        end
        if (!mon_enable)
            return;
        case (it.mode)
            MODE_ACCOUNT: begin
                if (it.bucket != BUCKET_NONE)
                    mon_bucket[it.bucket] += it.now_us - it.start_us;
            end
            MODE_BEGIN: begin
                mon_frame_start = it.now_us;
                mon_bucket[0] = '0;
                mon_bucket[1] = '0;
                mon_bucket[2] = '0;
            end
            default: fold_frame(it.now_us);
        endcase
    endtask

    // Sender: random gaps unless the calm flag is set; holds valid until accepted.
    // Valid drops after each transfer; the block is busy then anyway.
    task automatic send_event(t_in_item it);
        if (!src_calm) begin
            while ($urandom_range(99) < 25)
                @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        apply_event(it);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_event(logic [1:0] mode, logic [1:0] bucket,
                                            logic [31:0] start, logic [31:0] now,
                                            logic [31:0] sec);
        t_in_item it;
        it.mode = mode;
        it.bucket = bucket;
        it.start_us = start;
        it.now_us = now;
        it.read_second = sec;
        return it;
    endfunction

    // Registers are written only once the block is idle and every result is back.
    task automatic write_reg(logic [FTS_CFG_IDX_W-1:0] idx, logic [31:0] data);
        while (!o_in_ready || pending_reads.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ENABLE) mon_enable = data[0];
        else if (idx == CFG_SECOND_LEN) mon_sec_len = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every expected read result, then lets a frame end finish.
    task automatic drain_results();
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Output side: random stalls, or a long forced hold when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= !sink_hold && (sink_calm || $urandom_range(99) >= 25);
    end

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = pending_reads.pop_front();
                if (want !== o_out_data) begin
                    $display("%0t: mismatch expected %p", $time, want);
                    $display("%0t:          actual   %p", $time, o_out_data);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transfer of any kind happens.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT + 3 * RING) begin
            $display("per_second_frame_time_stats_top verification failed");
            $finish;
        end
    end

    // Directed: disabled events, read edge cases, every bucket and wrap-around.
    task automatic test_directed();
        send_event(make_event(MODE_END, BUCKET_SUBMIT, 0, 32'd50, 0));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 0));
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_SECOND_LEN, 32'hFFFF_FFFF);
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 0));
        send_event(make_event(MODE_BEGIN, BUCKET_SUBMIT, 0, 32'hFFFF_FFF0, 0));
        send_event(make_event(MODE_ACCOUNT, BUCKET_SUBMIT, 32'hFFFF_FFFF, 32'd5, 0));
        send_event(make_event(MODE_ACCOUNT, BUCKET_GPWAIT, 32'd0, 32'hFFFF_FFFF, 0));
        send_event(make_event(MODE_ACCOUNT, BUCKET_VSYNC, 32'd10, 32'hFFFF_0000, 0));
        send_event(make_event(MODE_ACCOUNT, BUCKET_NONE, 32'd0, 32'd999, 0));
        send_event(make_event(MODE_END, BUCKET_SUBMIT, 0, 32'd20, 0));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 0));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 32'd1));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 32'hFFFF_FFFF));
        send_event(make_event(MODE_BEGIN, BUCKET_SUBMIT, 0, 32'd100, 0));
        send_event(make_event(MODE_ACCOUNT, BUCKET_SUBMIT, 32'd100, 32'd140, 0));
        send_event(make_event(MODE_END, BUCKET_SUBMIT, 0, 32'd400, 0));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 0));
        drain_results();
        // With a zero second length every frame end rolls over.
        write_reg(CFG_SECOND_LEN, 32'd0);
        send_event(make_event(MODE_END, BUCKET_SUBMIT, 0, 32'd500, 0));
        send_event(make_event(MODE_END, BUCKET_SUBMIT, 0, 32'd600, 0));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 32'd1));
        send_event(make_event(MODE_READ, BUCKET_NONE, 0, 0, 32'd2));
        drain_results();
    endtask

    // Random frames: begin, accounts, end, with random events and reads of recent, stale and future seconds.
    task automatic test_random_frames(int count, logic [31:0] max_len);
        logic [31:0] clock_us;
        logic [31:0] sec;
        int sent;
        clock_us = $urandom;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0: begin
                    send_event(make_event(2'($urandom), 2'($urandom), $urandom, $urandom,
                                          $urandom));
                    sent++;
                end
                1, 2: begin
                    sec = mon_sec_idx - $urandom_range(4);
                    if ($urandom_range(5) == 0) sec = mon_sec_idx + 1;
                    if ($urandom_range(5) == 0) sec = mon_sec_idx - RING;
                    if ($urandom_range(7) == 0) sec = $urandom;
                    send_event(make_event(MODE_READ, 2'($urandom), $urandom, $urandom, sec));
                    sent++;
                end
                default: begin
                    clock_us += $urandom_range(max_len);
                    send_event(make_event(MODE_BEGIN, 2'($urandom), $urandom, clock_us,
                                          $urandom));
                    repeat ($urandom_range(4)) begin
                        clock_us += $urandom_range(max_len / 4 + 1);
                        send_event(make_event(MODE_ACCOUNT, 2'($urandom_range(3)),
                            clock_us - $urandom_range(max_len), clock_us, $urandom));
                        sent++;
                    end
                    clock_us += $urandom_range(max_len);
                    send_event(make_event(MODE_END, 2'($urandom), $urandom, clock_us,
                                          $urandom));
                    sent += 2;
                end
            endcase
        end
    endtask

    // The output holds off while reads keep coming, so the block stalls its input.
    task automatic test_output_backpressure();
        int k;
        fork
            begin
                sink_hold = 1'b1;
                for (k = 0; k < 2000; k++) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                src_calm = 1'b1;
                repeat (8)
                    send_event(make_event(MODE_READ, BUCKET_SUBMIT, 0, 0,
                                          mon_sec_idx - $urandom_range(2)));
                src_calm = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        mon_enable = 1'b0;
        mon_sec_len = FTS_SECOND_LEN_RESET;
        mon_sec_idx = '0;
        mon_sec_start = '0;
        mon_frame_start = '0;
        foreach (mon_bucket[b]) mon_bucket[b] = '0;
        foreach (mon_ring[s]) mon_ring[s] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_reg(CFG_SECOND_LEN, 32'd1);
        test_random_frames(150, 32'd3);
        drain_results();
        write_reg(CFG_SECOND_LEN, 32'd2000);
        sink_calm = 1'b1;
        src_calm = 1'b1;
        test_random_frames(150, 32'd400);
        sink_calm = 1'b0;
        src_calm = 1'b0;
        drain_results();
        write_reg(CFG_SECOND_LEN, 32'hFFFF_FFFF);
        test_random_frames(120, 32'hFFFF_FFFF);
        drain_results();
        test_output_backpressure();
        write_reg(CFG_ENABLE, 32'd0);
        test_random_frames(40, 32'd100);
        drain_results();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_SECOND_LEN, FTS_SECOND_LEN_RESET);
        test_random_frames(150, 32'd30000);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_reads.size() == 0)
            $display("per_second_frame_time_stats_top verification clean");
        else
            $display("per_second_frame_time_stats_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/fts_pkg.sv
hw/rtl/fts_div.sv
hw/rtl/fts_dp.sv
hw/rtl/fts_ctrl.sv
hw/rtl/per_second_frame_time_stats_top.sv
hw/rtl/fts_chk.sv
tb/tb.sv
